>>> rtl/ansi_sgr_color_parser_core_assert.svh
`ifndef ANSI_SGR_COLOR_PARSER_CORE_ASSERT_SVH
`define ANSI_SGR_COLOR_PARSER_CORE_ASSERT_SVH

// Clocked check, switched off while reset is asserted.
`define ANSP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ansp check failed");

// Clocked check that also holds while reset is asserted.
`define ANSP_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ansp reset check failed");

`endif

>>> rtl/ansp_pkg.sv
`timescale 1ns / 1ps

package ansp_pkg;

  localparam int unsigned UNIT_W      = 16;
  localparam int unsigned RGB_W       = 24;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned TDATA_OUT_W = 64;
  localparam int unsigned TUSER_OUT_W = 3;

  typedef struct packed {
    logic [LEVEL_W-1:0] dark;
    logic [LEVEL_W-1:0] bright_base;
    logic [LEVEL_W-1:0] bright_lit;
  } levels_t;

  // Source of the unit loaded into the output register.
  typedef enum logic [1:0] {
    SRC_INPUT = 2'd0,
    SRC_MEM   = 2'd1,
    SRC_HELD  = 2'd2
  } out_src_e;

  // What an accepted unit causes: a flush of the buffered sequence,
  // then possibly the unit itself.
  typedef struct packed {
    logic flush;
    logic emit;
  } plan_t;

  typedef struct packed {
    plan_t plan;
    logic  out_free;
    logic  rd_last;
  } dp_stat_t;

  typedef struct packed {
    logic     take;
    logic     rd_next;
    logic     load;
    out_src_e src;
    logic     last;
  } dp_cmd_t;

endpackage

>>> rtl/ansp_cfg.sv
`timescale 1ns / 1ps

module ansp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ansp_pkg::APB_AW-1:0]  paddr,
  input  logic [ansp_pkg::APB_DW-1:0]  pwdata,
  output logic [ansp_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output ansp_pkg::levels_t            levels_o
);

  localparam int unsigned DW = ansp_pkg::APB_DW;
  localparam int unsigned LW = ansp_pkg::LEVEL_W;

  localparam logic [1:0] REG_LEVEL_DARK        = 2'd0;
  localparam logic [1:0] REG_LEVEL_BRIGHT_BASE = 2'd1;
  localparam logic [1:0] REG_LEVEL_BRIGHT_LIT  = 2'd2;

  localparam logic [LW-1:0] DARK_RST        = 8'd187;
  localparam logic [LW-1:0] BRIGHT_BASE_RST = 8'd85;
  localparam logic [LW-1:0] BRIGHT_LIT_RST  = 8'd255;

  ansp_pkg::levels_t levels_q, levels_d;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    levels_d = levels_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_LEVEL_DARK:        levels_d.dark        = pwdata[LW-1:0];
        REG_LEVEL_BRIGHT_BASE: levels_d.bright_base = pwdata[LW-1:0];
        REG_LEVEL_BRIGHT_LIT:  levels_d.bright_lit  = pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEVEL_DARK:        prdata = {{(DW-LW){1'b0}}, levels_q.dark};
      REG_LEVEL_BRIGHT_BASE: prdata = {{(DW-LW){1'b0}}, levels_q.bright_base};
      REG_LEVEL_BRIGHT_LIT:  prdata = {{(DW-LW){1'b0}}, levels_q.bright_lit};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q.dark        <= DARK_RST;
      levels_q.bright_base <= BRIGHT_BASE_RST;
      levels_q.bright_lit  <= BRIGHT_LIT_RST;
    end else begin
      levels_q <= levels_d;
    end
  end

  assign levels_o = levels_q;

endmodule

>>> rtl/ansp_ctrl.sv
`timescale 1ns / 1ps

module ansp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  ansp_pkg::dp_stat_t stat_i,
  output ansp_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_LOAD = 2'd2,
    ST_EMIT = 2'd3
  } state_e;

  state_e state_q, state_d;
  logic   emit_q, emit_d;

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    state_d   = state_q;
    emit_d    = emit_q;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = stat_i.out_free;
        if (s_valid_i && stat_i.out_free) begin
          cmd_o.take = 1'b1;
          emit_d     = stat_i.plan.emit;
          if (stat_i.plan.flush) begin
            state_d = ST_READ;
          end else if (stat_i.plan.emit) begin
            // plain unit goes straight to the output register
            cmd_o.load = 1'b1;
            cmd_o.src  = ansp_pkg::SRC_INPUT;
            cmd_o.last = 1'b1;
          end
        end
      end
      ST_READ: begin
        // wait for the registered buffer read
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.src     = ansp_pkg::SRC_MEM;
          cmd_o.last    = stat_i.rd_last && !emit_q;
          cmd_o.rd_next = 1'b1;
          if (stat_i.rd_last) begin
            state_d = emit_q ? ST_EMIT : ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.src  = ansp_pkg::SRC_HELD;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

endmodule

>>> rtl/ansp_dp.sv
`timescale 1ns / 1ps

module ansp_dp #(
  parameter int unsigned SEQ_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ansp_pkg::UNIT_W-1:0]   unit_i,
  input  logic                          eot_i,
  input  ansp_pkg::levels_t             levels_i,
  input  ansp_pkg::dp_cmd_t             cmd_i,
  output ansp_pkg::dp_stat_t            stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ansp_pkg::UNIT_W-1:0]   out_unit_o,
  output logic [ansp_pkg::RGB_W-1:0]    out_fg_o,
  output logic                          out_fg_def_o,
  output logic [ansp_pkg::RGB_W-1:0]    out_bg_o,
  output logic                          out_bg_def_o,
  output logic                          out_ul_o,
  output logic                          out_last_o
);

  localparam int unsigned UW = ansp_pkg::UNIT_W;
  localparam int unsigned CW = $clog2(SEQ_DEPTH + 1);
  localparam int unsigned IW = $clog2(SEQ_DEPTH);

  localparam logic [UW-1:0] CH_ESC  = 16'h001B;
  localparam logic [UW-1:0] CH_LB   = 16'h005B;
  localparam logic [UW-1:0] CH_ZERO = 16'h0030;
  localparam logic [UW-1:0] CH_NINE = 16'h0039;
  localparam logic [UW-1:0] CH_SEMI = 16'h003B;
  localparam logic [UW-1:0] CH_M    = 16'h006D;

  localparam logic [6:0] P_RESET  = 7'd0;
  localparam logic [6:0] P_BRIGHT = 7'd1;
  localparam logic [6:0] P_UL     = 7'd4;
  localparam logic [6:0] P_NORMAL = 7'd22;
  localparam logic [6:0] P_NO_UL  = 7'd24;
  localparam logic [6:0] P_FG_LO  = 7'd30;
  localparam logic [6:0] P_FG_HI  = 7'd37;
  localparam logic [6:0] P_BG_LO  = 7'd40;
  localparam logic [6:0] P_BG_HI  = 7'd47;
  localparam logic [6:0] PV_MAX   = 7'd100;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_PARAM = 2'd2
  } mode_e;

  typedef struct packed {
    logic [ansp_pkg::RGB_W-1:0] fg;
    logic                       fg_def;
    logic [ansp_pkg::RGB_W-1:0] bg;
    logic                       bg_def;
    logic                       ul;
    logic                       br;
  } attr_t;

  localparam attr_t ATTR_RST = '{fg: '0, fg_def: 1'b1, bg: '0, bg_def: 1'b1,
                                 ul: 1'b0, br: 1'b0};

  function automatic logic [ansp_pkg::RGB_W-1:0] palette(
    input logic [2:0] idx, input logic br, input ansp_pkg::levels_t lv);
    logic [ansp_pkg::LEVEL_W-1:0] lit;
    logic [ansp_pkg::LEVEL_W-1:0] off;
    lit = br ? lv.bright_lit : lv.dark;
    off = br ? lv.bright_base : '0;
    return {idx[0] ? lit : off, idx[1] ? lit : off, idx[2] ? lit : off};
  endfunction

  function automatic attr_t apply_param(
    input logic [6:0] v, input attr_t a, input ansp_pkg::levels_t lv);
    attr_t r;
    r = a;
    if (v == P_RESET) begin
      r = ATTR_RST;
    end else if (v == P_BRIGHT) begin
      r.br = 1'b1;
    end else if (v == P_NORMAL) begin
      r.br = 1'b0;
    end else if (v == P_UL) begin
      r.ul = 1'b1;
    end else if (v == P_NO_UL) begin
      r.ul = 1'b0;
    end else if (v >= P_FG_LO && v <= P_FG_HI) begin
      r.fg     = palette(3'(v - P_FG_LO), a.br, lv);
      r.fg_def = 1'b0;
    end else if (v >= P_BG_LO && v <= P_BG_HI) begin
      r.bg     = palette(3'(v - P_BG_LO), a.br, lv);
      r.bg_def = 1'b0;
    end
    return r;
  endfunction

  // parser state
  mode_e         mode_q;
  logic [CW-1:0] count_q;
  logic [6:0]    pv_q;
  logic          hd_q;
  attr_t         attr_q;
  attr_t         shadow_q;

  // sequence buffer; entry 0 is always ESC and is never stored
  logic [UW-1:0] mem [SEQ_DEPTH];
  logic [UW-1:0] rdata_q;
  logic [IW-1:0] ptr_q;
  logic [CW-1:0] flush_len_q;
  logic [UW-1:0] held_unit_q;

  // output register
  logic                        out_valid_q;
  logic [UW-1:0]               out_unit_q;
  logic [ansp_pkg::RGB_W-1:0]  out_fg_q;
  logic                        out_fg_def_q;
  logic [ansp_pkg::RGB_W-1:0]  out_bg_q;
  logic                        out_bg_def_q;
  logic                        out_ul_q;
  logic                        out_last_q;

  logic          is_esc, is_lb, is_dig, is_semi, is_m;
  logic          room, in_seq, seq_ok, commit, fail, plain, start;
  logic [10:0]   nv;
  logic [6:0]    pv_dig;
  attr_t         shadow_applied;
  logic [UW-1:0] load_unit;

  always_comb begin
    is_esc  = (unit_i == CH_ESC);
    is_lb   = (unit_i == CH_LB);
    is_dig  = (unit_i >= CH_ZERO) && (unit_i <= CH_NINE);
    is_semi = (unit_i == CH_SEMI);
    is_m    = (unit_i == CH_M);
    room    = (count_q < CW'(SEQ_DEPTH));
    in_seq  = (mode_q == MODE_ESC) || (mode_q == MODE_PARAM);
    seq_ok  = 1'b0;
    commit  = 1'b0;
    unique case (mode_q)
      MODE_ESC:   seq_ok = is_lb && room;
      MODE_PARAM: begin
        seq_ok = (is_dig || is_semi) && room;
        commit = !seq_ok && is_m && (count_q > CW'(2));
      end
      default: ;
    endcase
    fail  = in_seq && !seq_ok && !commit;
    plain = !in_seq || fail;
    // ESC opens a sequence unless the text ends on it
    start = plain && is_esc && !eot_i;
    stat_o.plan.flush = fail || (seq_ok && eot_i);
    stat_o.plan.emit  = (plain && !start) || (seq_ok && eot_i);
    stat_o.rd_last    = ((CW'(ptr_q) + CW'(1)) == flush_len_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // decimal accumulate with saturation
  always_comb begin
    nv     = {1'b0, pv_q, 3'b000} + {3'b000, pv_q, 1'b0} + {7'd0, unit_i[3:0]};
    pv_dig = ((pv_q >= PV_MAX) || (nv > 11'(PV_MAX))) ? PV_MAX : nv[6:0];
    shadow_applied = hd_q ? apply_param(pv_q, shadow_q, levels_i) : shadow_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PLAIN;
      count_q  <= '0;
      pv_q     <= '0;
      hd_q     <= 1'b0;
      attr_q   <= ATTR_RST;
      shadow_q <= ATTR_RST;
    end else if (cmd_i.take) begin
      if (start) begin
        mode_q  <= MODE_ESC;
        count_q <= CW'(1);
      end else if (plain) begin
        mode_q  <= MODE_PLAIN;
        count_q <= '0;
      end else if (commit) begin
        attr_q   <= shadow_applied;
        shadow_q <= shadow_applied;
        pv_q     <= '0;
        hd_q     <= 1'b0;
        mode_q   <= MODE_PLAIN;
        count_q  <= '0;
      end else if (seq_ok) begin
        if (eot_i) begin
          mode_q  <= MODE_PLAIN;
          count_q <= '0;
        end else begin
          count_q <= count_q + CW'(1);
          if (mode_q == MODE_ESC) begin
            mode_q   <= MODE_PARAM;
            shadow_q <= attr_q;
            pv_q     <= '0;
            hd_q     <= 1'b0;
          end else if (is_dig) begin
            pv_q <= pv_dig;
            hd_q <= 1'b1;
          end else begin
            shadow_q <= shadow_applied;
            pv_q     <= '0;
            hd_q     <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && seq_ok && !eot_i) begin
      mem[count_q[IW-1:0]] <= unit_i;
    end
    rdata_q <= (ptr_q == '0) ? CH_ESC : mem[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      flush_len_q <= '0;
    end else if (cmd_i.take) begin
      ptr_q       <= '0;
      flush_len_q <= count_q;
    end else if (cmd_i.rd_next) begin
      ptr_q <= ptr_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      held_unit_q <= unit_i;
    end
  end

  always_comb begin
    case (cmd_i.src)
      ansp_pkg::SRC_MEM:  load_unit = rdata_q;
      ansp_pkg::SRC_HELD: load_unit = held_unit_q;
      default:            load_unit = unit_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_unit_q   <= load_unit;
      out_fg_q     <= attr_q.fg_def ? '0 : attr_q.fg;
      out_fg_def_q <= attr_q.fg_def;
      out_bg_q     <= attr_q.bg_def ? '0 : attr_q.bg;
      out_bg_def_q <= attr_q.bg_def;
      out_ul_q     <= attr_q.ul;
      out_last_q   <= cmd_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_unit_o   = out_unit_q;
  assign out_fg_o     = out_fg_q;
  assign out_fg_def_o = out_fg_def_q;
  assign out_bg_o     = out_bg_q;
  assign out_bg_def_o = out_bg_def_q;
  assign out_ul_o     = out_ul_q;
  assign out_last_o   = out_last_q;

endmodule

>>> rtl/ansi_sgr_color_parser_core.sv
`timescale 1ns / 1ps

// SGR escape parser: takes one UTF-16 unit per beat and emits each plain
// character with its committed colors and underline. A plain unit is taken
// every cycle while the output is drained. A unit inside ESC [ ... m is
// taken and gives no beat; the closing m commits the new
// attributes. A failed sequence, or one cut off by tlast, replays the
// buffered units (registered read of the sequence buffer, SEQ_DEPTH
// units deep), then the unit that ended it unless that unit is an ESC
// opening a new sequence. tlast on the output marks the last beat caused
// by one input beat. Registers at 0x0, 0x4, 0x8: dark level, bright base
// level, bright lit level; write them only while the block is idle.
module ansi_sgr_color_parser_core #(
  parameter int unsigned SEQ_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ansp_pkg::UNIT_W-1:0]       s_axis_tdata,  // [15:0] text_unit
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] out_unit, [39:16] fg_rgb, [63:40] bg_rgb
  output logic [ansp_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  // [0] fg_default, [1] bg_default, [2] underline
  output logic [ansp_pkg::TUSER_OUT_W-1:0]  m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ansp_pkg::APB_AW-1:0]       paddr,
  input  logic [ansp_pkg::APB_DW-1:0]       pwdata,
  output logic [ansp_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  ansp_pkg::levels_t  levels;
  ansp_pkg::dp_stat_t stat;
  ansp_pkg::dp_cmd_t  cmd;

  logic [ansp_pkg::UNIT_W-1:0] out_unit;
  logic [ansp_pkg::RGB_W-1:0]  out_fg;
  logic [ansp_pkg::RGB_W-1:0]  out_bg;
  logic                        out_fg_def;
  logic                        out_bg_def;
  logic                        out_ul;

  ansp_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .levels_o (levels)
  );

  ansp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ansp_dp #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .unit_i       (s_axis_tdata),
    .eot_i        (s_axis_tlast),
    .levels_i     (levels),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_unit_o   (out_unit),
    .out_fg_o     (out_fg),
    .out_fg_def_o (out_fg_def),
    .out_bg_o     (out_bg),
    .out_bg_def_o (out_bg_def),
    .out_ul_o     (out_ul),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_bg, out_fg, out_unit};
  assign m_axis_tuser = {out_ul, out_bg_def, out_fg_def};

endmodule

>>> rtl/ansp_checker.sv
`timescale 1ns / 1ps

`include "ansi_sgr_color_parser_core_assert.svh"

module ansp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [ansp_pkg::TDATA_OUT_W-1:0]  out_data_i,
  input logic [ansp_pkg::TUSER_OUT_W-1:0]  out_user_i,
  input logic                              out_last_i
);

  logic                                                 stalled;
  logic [ansp_pkg::TDATA_OUT_W+ansp_pkg::TUSER_OUT_W:0] beat;

  assign stalled = out_valid_i && !out_ready_i;
  assign beat    = {out_last_i, out_user_i, out_data_i};

  // stalled beat holds
  `ANSP_ASSERT(a_out_hold, stalled |=> out_valid_i && $stable(beat))
  // no input taken while a result waits
  `ANSP_ASSERT(a_no_take_stalled, stalled |-> !in_ready_i)
  // default colors carry zero rgb
  `ANSP_ASSERT(a_fg_default_zero, out_valid_i && out_user_i[0] |-> out_data_i[39:16] == 24'd0)
  `ANSP_ASSERT(a_bg_default_zero, out_valid_i && out_user_i[1] |-> out_data_i[63:40] == 24'd0)
  `ANSP_ASSERT_ALWAYS(a_rst_no_beat, !rst_ni |-> !out_valid_i)

endmodule

bind ansi_sgr_color_parser_core ansp_checker u_ansp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (s_axis_tready),
  .out_valid_i (m_axis_tvalid),
  .out_ready_i (m_axis_tready),
  .out_data_i  (m_axis_tdata),
  .out_user_i  (m_axis_tuser),
  .out_last_i  (m_axis_tlast)
);
